>>> hdl/bhms_pkg.sv
// ----------------------------------------------------------------------------
// bhms_pkg: shared types and constants of the BCD H:MM:SS countdown timer
// Command codes, digit geometry, per-cell control and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package bhms_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_INC    = 3'd2;
    localparam logic [2:0] CMD_SWAP   = 3'd3;
    localparam logic [2:0] CMD_STORE  = 3'd4;
    localparam logic [2:0] CMD_RECALL = 3'd5;
    localparam logic [2:0] CMD_ACK    = 3'd6;

    // Digit geometry: cell 0 is seconds ones, cell 4 is hours
    localparam int N_DIGITS     = 5;
    localparam int DIGIT_W      = 4;
    localparam int PRESET_SLOTS = 3;
    localparam int SLOT_W       = 2;

    // Largest value of each digit position
    function automatic logic [DIGIT_W-1:0] digit_max(input int idx);
        logic [DIGIT_W-1:0] m;
        case (idx)
            1, 3:    m = 4'd5;
            default: m = 4'd9;
        endcase
        return m;
    endfunction

    // Command decode shared by all cells
    typedef struct packed {
        logic              clear;
        logic              swap;
        logic              store;
        logic              recall;
        logic              ack;
        logic              mark;
        logic [SLOT_W-1:0] slot;
    } cell_ctrl_t;

    // One result item
    typedef struct packed {
        logic [4:0] flags_other;
        logic [4:0] flags_active;
        logic       expired;
        logic [3:0] sec_ones;
        logic [2:0] sec_tens;
        logic [3:0] min_ones;
        logic [2:0] min_tens;
        logic [3:0] hours;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/bhms_digit_cell.sv
// ----------------------------------------------------------------------------
// bhms_digit_cell: one BCD digit of the countdown chain
// Holds the digit, its preset copies and its two dirty bits; takes a borrow
// from the cell below and hands a borrow to the cell above.
// ----------------------------------------------------------------------------
`default_nettype none

module bhms_digit_cell (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire bhms_pkg::cell_ctrl_t           ctrl,
    input  wire logic                           inc,
    input  wire logic                           borrow_in,
    input  wire logic [bhms_pkg::DIGIT_W-1:0]   max_val,
    output logic                                borrow_out,
    output logic                                zero,
    output logic [bhms_pkg::DIGIT_W-1:0]        digit_next,
    output logic                                act_next,
    output logic                                oth_next
);

    logic [bhms_pkg::DIGIT_W-1:0] digit_reg;
    logic [bhms_pkg::DIGIT_W-1:0] preset_reg [bhms_pkg::PRESET_SLOTS];
    logic                         act_reg;
    logic                         oth_reg;
    logic                         touched;

    assign zero       = (digit_reg == '0);
    assign borrow_out = borrow_in & zero;
    assign touched    = borrow_in | ctrl.clear | inc | ctrl.recall;

    // Work out the digit and dirty bits after this command
    always_comb begin
        digit_next = digit_reg;
        act_next   = act_reg;
        oth_next   = oth_reg;
        if (borrow_in) begin
            digit_next = zero ? max_val : digit_reg - 1'b1;
        end else if (ctrl.clear) begin
            digit_next = '0;
        end else if (inc) begin
            digit_next = (digit_reg < max_val) ? digit_reg + 1'b1 : '0;
        end else if (ctrl.recall) begin
            digit_next = preset_reg[ctrl.slot];
        end
        if (touched) begin
            act_next = 1'b1;
        end
        if (ctrl.mark) begin
            oth_next = oth_reg | act_next;
        end
        if (ctrl.swap) begin
            act_next = oth_reg;
            oth_next = act_reg;
        end
        if (ctrl.ack) begin
            act_next = 1'b0;
        end
    end

    // Commit on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= '0;
            act_reg   <= 1'b0;
            oth_reg   <= 1'b0;
            for (int i = 0; i < bhms_pkg::PRESET_SLOTS; i++) begin
                preset_reg[i] <= '0;
            end
        end else if (en) begin
            digit_reg <= digit_next;
            act_reg   <= act_next;
            oth_reg   <= oth_next;
            if (ctrl.store) begin
                preset_reg[ctrl.slot] <= digit_reg;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/bhms_out_buf.sv
// ----------------------------------------------------------------------------
// bhms_out_buf: result register with skid stage
// Holds finished results so the input side can pass one more result
// while the output side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module bhms_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire bhms_pkg::result_t in_data,
    output logic                   in_ready,
    output logic                   out_valid,
    output bhms_pkg::result_t      out_data,
    input  wire logic              out_ready
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    bhms_pkg::result_t out_data_reg;
    bhms_pkg::result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control: refill the output from the skid stage first, else from input
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/bcd_hms_countdown_timer_core.sv
// ----------------------------------------------------------------------------
// bcd_hms_countdown_timer_core: five-digit BCD H:MM:SS countdown timer
// The digit chain commits each accepted command; results are registered.
// Throughput: one command per cycle while the skid stage is empty.
// A stalled master side is absorbed by a one-entry skid stage.
// Reset: synchronous, active low; clears digits, dirty flags and presets.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_hms_countdown_timer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // cmd[2:0], digit_sel[5:3], slot[7:6]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // hours[3:0], min_tens[6:4], min_ones[10:7],
                                        // sec_tens[13:11], sec_ones[17:14], expired[18],
                                        // flags_active[23:19], flags_other[28:24], zero
);

    localparam int N = bhms_pkg::N_DIGITS;

    logic                 accept;
    logic [2:0]           cmd;
    logic [2:0]           digit_sel;
    logic [1:0]           slot;
    logic                 is_tick;
    logic                 any_nz;
    logic                 tick_en;
    logic                 sel_ok;
    logic                 slot_ok;
    bhms_pkg::cell_ctrl_t ctrl;
    logic [N:0]           borrow;
    logic [N-1:0]         zero;
    logic [N-1:0]         act_next;
    logic [N-1:0]         oth_next;
    logic [bhms_pkg::DIGIT_W-1:0] digit_next [N];
    bhms_pkg::result_t    res;
    bhms_pkg::result_t    m_res;

    assign accept    = s_tvalid && s_tready;
    assign cmd       = s_tdata[2:0];
    assign digit_sel = s_tdata[5:3];
    assign slot      = s_tdata[7:6];

    // Decode the command for the cells
    assign is_tick = accept && (cmd == bhms_pkg::CMD_TICK);
    assign any_nz  = !(&zero);
    assign tick_en = is_tick && any_nz;
    assign sel_ok  = int'(digit_sel) < N;
    assign slot_ok = int'(slot) < bhms_pkg::PRESET_SLOTS;

    always_comb begin
        ctrl.clear  = accept && (cmd == bhms_pkg::CMD_CLEAR);
        ctrl.swap   = accept && (cmd == bhms_pkg::CMD_SWAP);
        ctrl.store  = accept && (cmd == bhms_pkg::CMD_STORE) && slot_ok;
        ctrl.recall = accept && (cmd == bhms_pkg::CMD_RECALL) && slot_ok;
        ctrl.ack    = accept && (cmd == bhms_pkg::CMD_ACK);
        ctrl.slot   = slot;
        ctrl.mark   = tick_en || ctrl.clear || ctrl.recall
                   || (accept && (cmd == bhms_pkg::CMD_INC) && sel_ok);
    end

    // Chain of digit cells, borrow running upward from seconds ones
    assign borrow[0] = tick_en;

    for (genvar i = 0; i < N; i++) begin : g_cell
        bhms_digit_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (accept),
            .ctrl       (ctrl),
            .inc        (accept && (cmd == bhms_pkg::CMD_INC) && (digit_sel == 3'(i))),
            .borrow_in  (borrow[i]),
            .max_val    (bhms_pkg::digit_max(i)),
            .borrow_out (borrow[i+1]),
            .zero       (zero[i]),
            .digit_next (digit_next[i]),
            .act_next   (act_next[i]),
            .oth_next   (oth_next[i])
        );
    end

    // Assemble the result of this transfer
    always_comb begin
        res.sec_ones     = digit_next[0];
        res.sec_tens     = digit_next[1][2:0];
        res.min_ones     = digit_next[2];
        res.min_tens     = digit_next[3][2:0];
        res.hours        = digit_next[4];
        res.expired      = is_tick && !any_nz;
        res.flags_active = act_next;
        res.flags_other  = oth_next;
    end

    bhms_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (m_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {3'b000, m_res};

`ifndef ASSERT_OFF
    // Input side only stalls while a result is held
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // An expired tick leaves every digit at zero
    a_expired_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[18]) |-> (m_tdata[17:0] == 18'd0))
        else $error("expired reported with non-zero digits");

    // Digits stay within their BCD range
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= 4'd9) && (m_tdata[6:4] <= 3'd5)
                  && (m_tdata[10:7] <= 4'd9) && (m_tdata[13:11] <= 3'd5)
                  && (m_tdata[17:14] <= 4'd9))
        else $error("digit out of range");

    // Hold a stalled result steady until it is taken
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed before its transfer");
`endif

endmodule

`default_nettype wire
